### rtl/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg: shared types and constants for the tilt angle accelerator
// Angle table and the state type that one CORDIC cell passes to the next.
// ----------------------------------------------------------------------------
`default_nettype none
package ata_pkg;
   localparam int STEPS = 18;
   localparam int FRAC = 16;
   localparam int XW = 36;
   localparam int ZW = 24;
   localparam int LANES = 3;
   localparam logic [ZW-1:0] DEG90_Q = 24'(90 << FRAC);
   localparam logic [ZW-1:0] DEG180_Q = 24'(180 << FRAC);

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic num_zero;
      logic den_zero;
      logic den_neg;
      logic num_neg;
   } lane_type;

   function automatic logic signed [ZW-1:0] step_angle(input logic [4:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0: v = 24'sd2949131;
         5'd1: v = 24'sd1740974;
         5'd2: v = 24'sd919883;
         5'd3: v = 24'sd466947;
         5'd4: v = 24'sd234380;
         5'd5: v = 24'sd117304;
         5'd6: v = 24'sd58666;
         5'd7: v = 24'sd29335;
         5'd8: v = 24'sd14668;
         5'd9: v = 24'sd7334;
         5'd10: v = 24'sd3667;
         5'd11: v = 24'sd1833;
         5'd12: v = 24'sd917;
         5'd13: v = 24'sd458;
         5'd14: v = 24'sd229;
         5'd15: v = 24'sd115;
         5'd16: v = 24'sd57;
         5'd17: v = 24'sd29;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

### rtl/accel_tilt_angles.sv
// An accepted start passes the input register, the 18 cells and the output register to rsp_valid.
// Throughput: one transaction per cycle; busy is tied low.
// Rate set by the 18-cell CORDIC chain, one vectoring step per cell.
// Reset clears the valid bits of the chain; payload carries no reset.
// The receiver cannot stall: rsp_valid marks each result for one cycle.
// ----------------------------------------------------------------------------
// accel_tilt_angles: heading, pitch and roll from raw accelerometer words
// Input decode, an 18-cell CORDIC chain and quadrant placement.
// ----------------------------------------------------------------------------
`default_nettype none
module accel_tilt_angles (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [15:0] req_x_raw,
   input  wire logic [15:0] req_y_raw,
   input  wire logic [15:0] req_z_raw,
   output logic rsp_valid,
   output logic signed [8:0] rsp_heading_deg,
   output logic signed [8:0] rsp_pitch_deg,
   output logic signed [8:0] rsp_roll_deg
);
   localparam int N = ata_pkg::STEPS;
   ata_pkg::lane_type chain [N+1][ata_pkg::LANES];
   logic valid [N+1];
   ata_pkg::lane_type lane_ff [ata_pkg::LANES];
   logic in_valid_ff;
   logic out_valid_ff;
   logic signed [8:0] ang_ff [ata_pkg::LANES];
   logic signed [8:0] ang_in [ata_pkg::LANES];
   logic xn, yn, zn;
   logic [15:0] xm, ym, zm;
   ata_pkg::lane_type lane_in [ata_pkg::LANES];

   assign busy = 1'b0;
   assign xn = req_x_raw > 16'hFFF;
   assign yn = req_y_raw > 16'hFFF;
   assign zn = req_z_raw > 16'hFFF;
   assign xm = xn ? 16'(-req_x_raw) : req_x_raw;
   assign ym = yn ? 16'(-req_y_raw) : req_y_raw;
   assign zm = zn ? 16'(-req_z_raw) : req_z_raw;

   function automatic ata_pkg::lane_type mk(input logic [15:0] nm, input logic nneg,
                                            input logic [15:0] dm, input logic dneg,
                                            input logic dzero);
      ata_pkg::lane_type l;
      l.x = ata_pkg::XW'({dm, 16'h0});
      l.y = ata_pkg::XW'({nm, 16'h0});
      l.z = '0;
      l.num_zero = (nm == 16'h0);
      l.den_zero = dzero;
      l.den_neg = dneg;
      l.num_neg = nneg;
      return l;
   endfunction

   always_comb begin
      lane_in[0] = mk(ym, !yn, xm, xn, req_x_raw == 16'h0);
      lane_in[1] = mk(xm, xn, zm, zn, req_z_raw == 16'h0);
      lane_in[2] = mk(ym, yn, zm, zn, req_z_raw == 16'h0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      lane_ff <= lane_in;
   end

   assign chain[0] = lane_ff;
   assign valid[0] = in_valid_ff;

   for (genvar g = 0; g < N; g++) begin : g_cell
      ata_cell u_cell (
         .clock(clock),
         .reset(reset),
         .step(5'(g)),
         .valid_in(valid[g]),
         .lane_in(chain[g]),
         .valid_out(valid[g+1]),
         .lane_out(chain[g+1])
      );
   end

   always_comb begin
      for (int k = 0; k < ata_pkg::LANES; k++) begin
         logic signed [ata_pkg::ZW-1:0] f;
         logic [ata_pkg::ZW-1:0] m;
         logic [8:0] w;
         f = chain[N][k].z;
         if (chain[N][k].num_zero || f < 0) begin
            f = '0;
         end else if (f > $signed(ata_pkg::DEG90_Q - 24'd1)) begin
            f = $signed(ata_pkg::DEG90_Q - 24'd1);
         end
         m = chain[N][k].den_neg ? ata_pkg::DEG180_Q - f : f;
         w = 9'(m >> ata_pkg::FRAC);
         if (chain[N][k].den_zero) begin
            w = 9'd90;
         end
         ang_in[k] = chain[N][k].num_neg ? -$signed(w) : $signed(w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid[N];
      end
      ang_ff <= ang_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_heading_deg = ang_ff[0];
   assign rsp_pitch_deg = ang_ff[1];
   assign rsp_roll_deg = ang_ff[2];

`ifndef SYNTH
   a_lat: assert property (@(posedge clock) disable iff (reset)
      valid[N] |=> rsp_valid) else $error("result strobe lost");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_deg <= 9'sd180 && rsp_pitch_deg >= -9'sd180))
      else $error("pitch out of range");
   a_nobusy: assert property (@(posedge clock) !busy) else $error("busy raised");
`endif
endmodule
`default_nettype wire

### rtl/ata_cell.sv
// ----------------------------------------------------------------------------
// ata_cell: one CORDIC vectoring step for all three angle lanes
// Rotates each lane by the fixed step angle and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none
module ata_cell (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [4:0] step,
   input  wire logic valid_in,
   input  wire ata_pkg::lane_type lane_in [ata_pkg::LANES],
   output logic valid_out,
   output ata_pkg::lane_type lane_out [ata_pkg::LANES]
);
   ata_pkg::lane_type lane_in_c [ata_pkg::LANES];
   logic valid_ff;
   ata_pkg::lane_type lane_ff [ata_pkg::LANES];

   always_comb begin
      for (int k = 0; k < ata_pkg::LANES; k++) begin
         lane_in_c[k] = lane_in[k];
         if (!lane_in[k].y[ata_pkg::XW-1]) begin
            lane_in_c[k].x = lane_in[k].x + (lane_in[k].y >>> step);
            lane_in_c[k].y = lane_in[k].y - (lane_in[k].x >>> step);
            lane_in_c[k].z = lane_in[k].z + ata_pkg::step_angle(step);
         end else begin
            lane_in_c[k].x = lane_in[k].x - (lane_in[k].y >>> step);
            lane_in_c[k].y = lane_in[k].y + (lane_in[k].x >>> step);
            lane_in_c[k].z = lane_in[k].z - ata_pkg::step_angle(step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      lane_ff <= lane_in_c;
   end

   assign valid_out = valid_ff;
   assign lane_out = lane_ff;
endmodule
`default_nettype wire

### test/tilt_checker.sv
// ----------------------------------------------------------------------------
// tilt_checker: expected-angle store and comparison for accel_tilt_angles
// Computes heading, pitch and roll for each accepted transaction and checks
// every result strobe against the oldest expected triple.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tilt_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic [15:0] req_x_raw,
   input  logic [15:0] req_y_raw,
   input  logic [15:0] req_z_raw,
   input  logic rsp_valid,
   input  logic signed [8:0] rsp_heading_deg,
   input  logic signed [8:0] rsp_pitch_deg,
   input  logic signed [8:0] rsp_roll_deg,
   output int errors,
   output int pending,
   output int checked
);
   typedef struct packed {
      logic signed [8:0] heading;
      logic signed [8:0] pitch;
      logic signed [8:0] roll;
   } angles_t;

   localparam longint Q90 = 64'd90 <<< 16;
   localparam longint Q180 = 64'd180 <<< 16;

   angles_t expected_angles[$];

   function automatic longint rotation_angle(input int i);
      longint t[18] = '{2949131, 1740974, 919883, 466947, 234380, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
      return t[i];
   endfunction

   function automatic bit is_neg(input logic [15:0] w);
      return w > 16'hFFF;
   endfunction

   function automatic longint magnitude(input logic [15:0] w);
      logic [15:0] m;
      m = is_neg(w) ? 16'(-w) : w;
      return longint'(m);
   endfunction

   function automatic longint vector_atan(input longint num, input longint den);
      longint x, y, z, dx, dy;
      x = den <<< 16;
      y = num <<< 16;
      z = 0;
      if (num == 0) return 0;
      for (int i = 0; i < 18; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += rotation_angle(i);
         end else begin
            x -= dx; y += dy; z -= rotation_angle(i);
         end
      end
      if (z < 0) z = 0;
      if (z > Q90 - 1) z = Q90 - 1;
      return z;
   endfunction

   function automatic logic signed [8:0] place_angle(input longint num_mag,
         input bit num_neg, input logic [15:0] den_raw);
      longint f, m;
      if (den_raw == 0) return num_neg ? -9'sd90 : 9'sd90;
      f = vector_atan(num_mag, magnitude(den_raw));
      m = (is_neg(den_raw) ? (Q180 - f) : f) >>> 16;
      return 9'(num_neg ? -m : m);
   endfunction

   always_ff @(posedge clock) begin
      angles_t e;
      if (reset) begin
         errors <= 0;
         pending <= 0;
         checked <= 0;
      end else begin
         if (start && !busy) begin
            e.heading = place_angle(magnitude(req_y_raw), !is_neg(req_y_raw), req_x_raw);
            e.pitch = place_angle(magnitude(req_x_raw), is_neg(req_x_raw), req_z_raw);
            e.roll = place_angle(magnitude(req_y_raw), is_neg(req_y_raw), req_z_raw);
            expected_angles.push_back(e);
         end
         if (rsp_valid) begin
            if (expected_angles.size() == 0) begin
               $display("%0t: result with no transaction pending: %0d %0d %0d", $time,
                        rsp_heading_deg, rsp_pitch_deg, rsp_roll_deg);
               errors <= errors + 1;
            end else begin
               e = expected_angles.pop_front();
               if (e.heading !== rsp_heading_deg || e.pitch !== rsp_pitch_deg ||
                   e.roll !== rsp_roll_deg) begin
                  $display("%0t: expected h/p/r %0d %0d %0d, actual %0d %0d %0d", $time,
                           e.heading, e.pitch, e.roll,
                           rsp_heading_deg, rsp_pitch_deg, rsp_roll_deg);
                  errors <= errors + 1;
               end
               checked <= checked + 1;
            end
         end
         pending <= expected_angles.size();
      end
   end
endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for accel_tilt_angles
// Drives directed axis corners, then bursty random transactions, and reports
// the checker's result once the pipeline has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic [15:0] req_x_raw = 0, req_y_raw = 0, req_z_raw = 0;
   logic busy, rsp_valid;
   logic signed [8:0] rsp_heading_deg, rsp_pitch_deg, rsp_roll_deg;
   int errors, pending, checked;
   int cycles = 0;
   int sent = 0;

   always #5 clock = ~clock;

   accel_tilt_angles u_dut (.*);

   tilt_checker u_check (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [15:0] axis_word();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 4095));
         1: return 16'($urandom_range(4096, 65535));
         2: return 16'(-$urandom_range(1, 4095));
         3: return 16'($urandom_range(0, 3));
         4: return 16'($urandom);
         default: return 16'(-$urandom_range(0, 3));
      endcase
   endfunction

   task automatic send(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
      req_x_raw <= x;
      req_y_raw <= y;
      req_z_raw <= z;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   task automatic idle(input int n);
      start <= 0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      logic [15:0] corner[8] = '{16'h0000, 16'h0001, 16'h0FFF, 16'h1000,
                                 16'hFFFF, 16'h8000, 16'hF001, 16'h0800};
      int burst;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 8; i++)
         send(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
      send(0, 0, 0);
      send(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send(100, 100, 100);
      send(16'(-100), 16'(-100), 16'(-100));
      send(0, 5, 0);
      send(0, 16'(-5), 0);
      send(7, 0, 16'(-7));
      send(16'h1000, 16'h1000, 16'h0FFF);
      idle(1);
      while (pending != 0 || checked < sent) @(posedge clock);
      idle(25);
      while (sent < 760) begin
         burst = $urandom_range(1, 40);
         repeat (burst) send(axis_word(), axis_word(), axis_word());
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 30));
      end
      idle(1);
      while (checked < sent) @(posedge clock);
      repeat (25) @(posedge clock);
      $display("Sent %0d transactions (directed corners and bursty random words);", sent);
      $display("checked %0d results, %0d mismatches.", checked, errors);
      if (errors == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
